// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define BRB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define BRB_NEVER(name, cond, msg) \
  `BRB_ASSERT(name, !(cond), msg)

`endif

// ----- rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// Types, constants and helpers for the byte ring buffer with line extract.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_DELIM = 4;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int DLW       = $clog2(MAX_DELIM + 1);
  localparam int PAW       = 3;

  // opcodes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PEEK    = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;
  localparam logic [1:0] OP_EXTRACT = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_DELIM_BYTES = 1'b0;
  localparam logic REG_DELIM_LEN   = 1'b1;

  localparam logic [31:0] DELIM_BYTES_RST = 32'h0000_0A0D;
  localparam logic [2:0]  DELIM_LEN_RST   = 3'd2;

  typedef struct packed {
    logic          accepted;
    logic [7:0]    read_byte;
    logic [CW-1:0] line_length;
    logic [CW-1:0] fill_level;
  } brb_res_t;

  typedef struct packed {
    logic take;       // word accepted this cycle
    logic peek_wait;  // peek data arriving from store
    logic scan_run;   // delimiter scan in progress
    logic res_load;   // result complete, push into output queue
  } brb_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } brb_stat_t;

  // circular add, n may be as large as DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(n);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // effective delimiter length: zero acts as one, clipped at MAX_DELIM
  function automatic logic [DLW-1:0] delim_len_eff(input logic [2:0] raw);
    logic [DLW-1:0] r;
    if (raw == 3'd0) r = DLW'(1);
    else if (32'(raw) > MAX_DELIM) r = DLW'(MAX_DELIM);
    else r = DLW'(raw);
    return r;
  endfunction

  // delimiter byte j, zero past the packed word
  function automatic logic [7:0] delim_byte(input logic [31:0] bytes,
                                            input logic [DLW-1:0] j);
    logic [7:0] b;
    if (32'(j) >= 4) b = 8'd0;
    else b = 8'(bytes >> {j, 3'b000});
    return b;
  endfunction

endpackage

// ----- rtl/brb_ifs.sv -----
// ----------------------------------------------------------------------------
// brb channel interfaces
// Request and response channels, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface brb_req_if import brb_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  logic [7:0]    data_byte;
  logic [AW-1:0] offset;
  logic [CW-1:0] count;

  modport source (output valid, op, data_byte, offset, count, input ready);
  modport sink   (input valid, op, data_byte, offset, count, output ready);
endinterface

interface brb_rsp_if import brb_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          accepted;
  logic [7:0]    read_byte;
  logic [CW-1:0] line_length;
  logic [CW-1:0] fill_level;

  modport source (output valid, accepted, read_byte, line_length, fill_level,
                  input ready);
  modport sink   (input valid, accepted, read_byte, line_length, fill_level,
                  output ready);
endinterface

// ----- rtl/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl
// Operation sequencer: takes a word, waits on peek data or the scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_ctrl import brb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  input  logic [1:0] op,
  input  logic      room,
  input  brb_stat_t stat,
  output logic      ready,
  output brb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PEEK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state, state_next;
  logic       take;

  assign ready = (state == S_IDLE) && room;
  assign take  = valid && ready;

  always_comb begin
    state_next    = state;
    cmd.take      = take;
    cmd.peek_wait = (state == S_PEEK);
    cmd.scan_run  = (state == S_SCAN);
    cmd.res_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (op == OP_PEEK) state_next = S_PEEK;
          else if (op == OP_EXTRACT) state_next = S_SCAN;
          else cmd.res_load = 1'b1;
        end
      end
      S_PEEK: begin
        cmd.res_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_SCAN: begin
        if (stat.hit || stat.miss) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `BRB_ASSERT(a_peek_one_cycle, state == S_PEEK |=> state == S_IDLE, "peek overstayed")

endmodule

// ----- rtl/brb_dp.sv -----
// ----------------------------------------------------------------------------
// brb_dp
// Byte store, pointers, fill count and the one-byte-per-cycle delimiter scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_dp import brb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  brb_cmd_t      cmd,
  input  logic [1:0]    op,
  input  logic [7:0]    data_byte,
  input  logic [AW-1:0] offset,
  input  logic [CW-1:0] count,
  input  logic [31:0]   delim_bytes,
  input  logic [2:0]    delim_len,
  output brb_stat_t     stat,
  output brb_res_t      res
);

  logic [7:0]     mem [DEPTH];
  logic [7:0]     rdata;
  logic [AW-1:0]  raddr;
  logic           wr_en;

  logic [AW-1:0]  rp, rp_next, wp, wp_next;
  logic [CW-1:0]  cnt, cnt_next;

  logic           push_ok, disc_ok, pk_in;
  logic [DLW-1:0] dl;

  // scan state
  logic [CW-1:0]  iss, seen, seen_now;
  logic           rd_vld, iss_go, mt, hit, miss;
  logic [7:0]     win  [MAX_DELIM];
  logic [7:0]     cand [MAX_DELIM];

  assign push_ok  = (count != '0) && (count <= CW'(DEPTH) - cnt);
  assign disc_ok  = (count <= cnt);
  assign dl       = delim_len_eff(delim_len);
  assign seen_now = seen + CW'(1);

  // newest byte at index 0
  always_comb begin
    cand[0] = rdata;
    for (int k = 1; k < MAX_DELIM; k++) cand[k] = win[k-1];
  end

  always_comb begin
    mt = 1'b1;
    for (int k = 0; k < MAX_DELIM; k++) begin
      if (DLW'(k) < dl &&
          cand[k] != delim_byte(delim_bytes, DLW'(dl - DLW'(1) - DLW'(k)))) mt = 1'b0;
    end
  end

  assign hit    = cmd.scan_run && rd_vld && (seen_now >= CW'(dl)) && mt;
  assign miss   = cmd.scan_run && !rd_vld && (iss >= cnt);
  assign iss_go = cmd.scan_run && (iss < cnt) && !hit;

  assign stat.hit  = hit;
  assign stat.miss = miss;

  assign raddr = cmd.scan_run ? wrap_add(rp, iss) : wrap_add(rp, CW'(offset));

  // pointer and count update
  always_comb begin
    rp_next  = rp;
    wp_next  = wp;
    cnt_next = cnt;
    wr_en    = 1'b0;
    if (cmd.take) begin
      case (op)
        OP_PUSH: begin
          if (push_ok) begin
            wr_en    = 1'b1;
            wp_next  = wrap_add(wp, CW'(1));
            cnt_next = cnt + CW'(1);
          end
        end
        OP_DISCARD: begin
          if (disc_ok) begin
            rp_next  = wrap_add(rp, count);
            cnt_next = cnt - count;
          end
        end
        default: ;
      endcase
    end
    if (hit) begin
      rp_next  = wrap_add(rp, seen_now);
      cnt_next = cnt - seen_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= '0;
      wp  <= '0;
      cnt <= '0;
    end else begin
      rp  <= rp_next;
      wp  <= wp_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= data_byte;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_vld <= 1'b0;
    else if (cmd.take) rd_vld <= 1'b0;
    else rd_vld <= iss_go;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      iss   <= '0;
      seen  <= '0;
      pk_in <= (CW'(offset) < cnt);
    end else begin
      if (iss_go) iss <= iss + CW'(1);
      if (rd_vld) begin
        seen <= seen_now;
        for (int k = 0; k < MAX_DELIM; k++) win[k] <= cand[k];
      end
    end
  end

  // result word, taken by the output queue on res_load
  always_comb begin
    res.fill_level  = cnt_next;
    res.accepted    = 1'b0;
    res.read_byte   = 8'd0;
    res.line_length = '0;
    if (cmd.scan_run) begin
      res.accepted = hit;
      if (hit) res.line_length = seen_now - CW'(dl);
    end else if (cmd.peek_wait) begin
      res.accepted  = 1'b1;
      res.read_byte = pk_in ? rdata : 8'd0;
    end else begin
      case (op)
        OP_PUSH:    res.accepted = push_ok;
        OP_DISCARD: res.accepted = disc_ok;
        default:    res.accepted = 1'b0;
      endcase
    end
  end

  `BRB_ASSERT(a_cnt_range, cnt <= CW'(DEPTH), "fill count beyond depth")
  `BRB_ASSERT(a_ptr_gap, wp == wrap_add(rp, cnt), "pointers disagree with fill count")
  `BRB_NEVER(a_hit_miss, hit && miss, "scan hit and miss together")

endmodule

// ----- rtl/brb_oq.sv -----
// ----------------------------------------------------------------------------
// brb_oq
// Two-entry result queue between the sequencer and the response channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_oq import brb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  brb_res_t din,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output brb_res_t dout
);

  brb_res_t   slot [2];
  logic       wr_sel, rd_sel;
  logic [1:0] occ;
  logic       pop;

  assign out_valid = (occ != 2'd0);
  assign room      = (occ != 2'd2);
  assign pop       = out_valid && out_ready;
  assign dout      = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (load) slot[wr_sel] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      occ    <= 2'd0;
    end else begin
      if (load) wr_sel <= !wr_sel;
      if (pop) rd_sel <= !rd_sel;
      occ <= occ + 2'(load) - 2'(pop);
    end
  end

  `BRB_NEVER(a_load_full, load && occ == 2'd2, "result pushed into full queue")

endmodule

// ----- rtl/byte_ring_buffer_with_line_extract_core.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_line_extract_core
// Circular byte store with push, peek, discard and delimiter line extract.
// ----------------------------------------------------------------------------
// A 1024-byte circular store driven one word at a time on the request
// channel; every word gives exactly one response word. Push appends a byte
// only if the announced remaining burst (count) fits in free space, so bulk
// writes land whole or not at all. Peek reads the byte at offset from the
// read point (zero past stored data). Discard drops count bytes, or fails if
// fewer are stored. Extract scans from the read point for the delimiter set
// over APB (reg 0 at 0x0: bytes, first in bits 7:0, reset CR LF; reg 1 at
// 0x4: length 1..4, reset 2, 0 acts as 1, above 4 acts as 4); on a hit it
// returns the line length without delimiter and consumes line plus
// delimiter, on a miss it fails and consumes nothing. Push and discard
// load their result when taken; peek waits on the registered store read.
// Extract on a hit scans the bytes up to the end of the delimiter; a miss
// scans all stored bytes, or none when the store is empty. The single
// store read port delivers one byte per cycle, which sets the scan time.
// Results sit in a two-entry queue, so a new word is taken while an earlier
// response is still waiting. The store is not cleared after reset; unwritten
// bytes are never returned.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_line_extract_core import brb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  brb_req_if.sink        request,
  brb_rsp_if.source      response,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  // configuration
  logic [31:0] delim_bytes;
  logic [2:0]  delim_len;
  logic        cfg_wr;
  logic        reg_sel;

  // sequencer <-> datapath / queue
  brb_cmd_t    cmd;
  brb_stat_t   stat;
  brb_res_t    res, q_out;
  logic        room;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes <= DELIM_BYTES_RST;
      delim_len   <= DELIM_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DELIM_BYTES: delim_bytes <= pwdata;
        REG_DELIM_LEN:   delim_len   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DELIM_BYTES: prdata = delim_bytes;
      REG_DELIM_LEN:   prdata = {29'd0, delim_len};
      default:         prdata = 32'd0;
    endcase
  end

  // sequencer: accepts a word only when idle and the queue has a free slot
  brb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (request.valid),
    .op    (request.op),
    .room  (room),
    .stat  (stat),
    .ready (request.ready),
    .cmd   (cmd)
  );

  // store, pointers, scan engine
  brb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (request.op),
    .data_byte   (request.data_byte),
    .offset      (request.offset),
    .count       (request.count),
    .delim_bytes (delim_bytes),
    .delim_len   (delim_len),
    .stat        (stat),
    .res         (res)
  );

  // response staging
  brb_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.res_load),
    .din       (res),
    .room      (room),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .dout      (q_out)
  );

  assign response.accepted    = q_out.accepted;
  assign response.read_byte   = q_out.read_byte;
  assign response.line_length = q_out.line_length;
  assign response.fill_level  = q_out.fill_level;

endmodule
